[design/rgba_color_matrix_filter_core_assert.svh]
// Assertion macros used by the color matrix filter checker.
`ifndef RGBA_COLOR_MATRIX_FILTER_CORE_ASSERT_SVH
`define RGBA_COLOR_MATRIX_FILTER_CORE_ASSERT_SVH

// Condition must hold on every clock edge out of reset.
`define CMF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed");

// Antecedent implies consequent on the same edge.
`define CMF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

[design/cmf_pkg.sv]
// Types and constants of the color matrix filter.
package cmf_pkg;
	localparam int COEF_BITS = 12;
	localparam int CFG_W = 60;
	localparam int NUM_ROWS = 4;
	localparam int NUM_TERMS = 4;
	localparam int MAG_W = COEF_BITS + 7;
	localparam int PROD_W = COEF_BITS + 8;
	localparam int SUM_W = MAG_W + 3;
	localparam int IDX_W = 3;
	localparam int OFFSET_K = 4;
	localparam logic [7:0] DIV_255 = 8'd255;

	localparam logic [IDX_W-1:0] REG_RED = 3'd0;
	localparam logic [IDX_W-1:0] REG_GREEN = 3'd1;
	localparam logic [IDX_W-1:0] REG_BLUE = 3'd2;
	localparam logic [IDX_W-1:0] REG_ALPHA = 3'd3;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
	} pixel_out_t;

	typedef logic [NUM_ROWS-1:0][CFG_W-1:0] cfg_rows_t;
endpackage

[design/cmf_cfg_regs.sv]
// Matrix row registers written through the plain write port.
module cmf_cfg_regs import cmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             write_en,
	input  logic [IDX_W-1:0] write_index,
	input  logic [CFG_W-1:0] write_data,
	output cfg_rows_t        rows
);
	cfg_rows_t rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
		end else if (write_en) begin
			unique case (write_index)
				REG_RED:   rows_q[0] <= write_data;
				REG_GREEN: rows_q[1] <= write_data;
				REG_BLUE:  rows_q[2] <= write_data;
				REG_ALPHA: rows_q[3] <= write_data;
				default: ;
			endcase
		end
	end

	assign rows = rows_q;
endmodule

[design/cmf_term_div.sv]
// Three-stage signed divide of one matrix term by an 8-bit divisor.
module cmf_term_div import cmf_pkg::*; (
	input  logic                     clk,
	input  logic signed [PROD_W-1:0] num,
	input  logic [7:0]               den,
	output logic signed [PROD_W-1:0] quo
);
	logic [MAG_W:0] recip_tab [256];

	genvar gi;
	for (gi = 0; gi < 256; gi++) begin : g_recip
		localparam logic [MAG_W:0] R = MAG_W'(1) << MAG_W;
		localparam int D = (gi == 0) ? 1 : gi;
		localparam logic [MAG_W:0] RV = (MAG_W+1)'(((64'd1) << MAG_W) / D);
		assign recip_tab[gi] = (gi == 0) ? R : RV;
	end

	logic [MAG_W-1:0] mag;
	logic [2*MAG_W:0] est_full;
	logic [MAG_W-1:0] mag_s2, q0_s2, mag_s3, q0_s3, p_s3;
	logic [7:0]       den_s2, den_s3;
	logic             neg_s2, neg_s3;
	logic [MAG_W+7:0] p_full;
	logic [MAG_W-1:0] rem, q;

	assign mag = num[PROD_W-1] ? MAG_W'(-num) : MAG_W'(num);
	assign est_full = mag * recip_tab[den];

	// estimate from the reciprocal is exact or one low
	always_ff @(posedge clk) begin
		mag_s2 <= mag;
		q0_s2  <= est_full[2*MAG_W-1:MAG_W];
		den_s2 <= den;
		neg_s2 <= num[PROD_W-1];
	end

	assign p_full = q0_s2 * den_s2;

	always_ff @(posedge clk) begin
		mag_s3 <= mag_s2;
		q0_s3  <= q0_s2;
		p_s3   <= p_full[MAG_W-1:0];
		den_s3 <= den_s2;
		neg_s3 <= neg_s2;
	end

	assign rem = mag_s3 - p_s3;
	assign q = (rem >= MAG_W'(den_s3)) ? q0_s3 + MAG_W'(1) : q0_s3;

	always_ff @(posedge clk) begin
		quo <= neg_s3 ? -$signed({1'b0, q}) : $signed({1'b0, q});
	end
endmodule

[design/rgba_color_matrix_filter_core.sv]
// Top level of the RGBA color matrix filter pipeline.
// Takes one premultiplied pixel per clock (busy never rises) and returns its
// filtered word with one done strobe per pixel, in order. The pipeline has
// seven stages: coefficient products, reciprocal estimate, check product,
// quotient correction, row sum with clamp, premultiply product, and divide
// by 255. Results cannot be held off. The user must write matrix rows only
// while no pixel is in flight; the block itself does not enforce this.
module rgba_color_matrix_filter_core import cmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pixel_in_t        pixel,
	output logic             done,
	output pixel_out_t       result,
	input  logic             write_en,
	input  logic [IDX_W-1:0] write_index,
	input  logic [CFG_W-1:0] write_data
);
	cfg_rows_t rows;

	cmf_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .write_en(write_en),
		.write_index(write_index), .write_data(write_data), .rows(rows)
	);

	assign busy = 1'b0;

	logic [6:0] vld;
	logic [3:0] zero;
	logic [7:0] px [NUM_TERMS];

	assign px[0] = pixel.red_in;
	assign px[1] = pixel.green_in;
	assign px[2] = pixel.blue_in;
	assign px[3] = pixel.alpha_in;

	logic signed [PROD_W-1:0] num_s1 [NUM_ROWS][NUM_TERMS];
	logic [7:0]               den_s1 [NUM_TERMS];
	logic signed [PROD_W-1:0] term_s4 [NUM_ROWS][NUM_TERMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld  <= '0;
			zero <= '0;
		end else begin
			vld  <= {vld[5:0], start & ~busy};
			zero <= {zero[2:0], pixel.alpha_in == 8'd0};
		end
	end

	genvar r, t;
	for (r = 0; r < NUM_ROWS; r++) begin : g_row
		for (t = 0; t < NUM_TERMS; t++) begin : g_term
			logic signed [COEF_BITS-1:0] coef;
			logic signed [PROD_W:0]      prod;
			assign coef = $signed(rows[r][t*COEF_BITS +: COEF_BITS]);
			assign prod = coef * $signed({1'b0, px[t]});
			always_ff @(posedge clk) begin
				num_s1[r][t] <= $signed(prod[PROD_W-1:0]);
			end
			cmf_term_div u_div (
				.clk(clk), .num(num_s1[r][t]), .den(den_s1[t]), .quo(term_s4[r][t])
			);
		end
	end

	always_ff @(posedge clk) begin
		den_s1[0] <= pixel.alpha_in;
		den_s1[1] <= pixel.alpha_in;
		den_s1[2] <= pixel.alpha_in;
		den_s1[3] <= DIV_255;
	end

	logic [7:0] res_s5 [NUM_ROWS];

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_ROWS; i++) begin
			logic signed [SUM_W-1:0] sum;
			sum = SUM_W'($signed(rows[i][OFFSET_K*COEF_BITS +: COEF_BITS]));
			// zero alpha keeps the offset alone
			if (!zero[3]) begin
				for (int j = 0; j < NUM_TERMS; j++) begin
					sum = sum + SUM_W'(term_s4[i][j]);
				end
			end
			if (sum < 0) res_s5[i] <= 8'd0;
			else if (sum > SUM_W'(255)) res_s5[i] <= 8'd255;
			else res_s5[i] <= sum[7:0];
		end
	end

	logic [15:0] prem_s6 [3];
	logic [7:0]  alpha_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prem_s6[i] <= res_s5[i] * res_s5[3];
		end
		alpha_s6 <= res_s5[3];
	end

	logic [16:0] scl [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// exact x/255 for x below 65535
			scl[i] = 17'(prem_s6[i]) + 17'd1 + 17'(prem_s6[i][15:8]);
		end
	end

	pixel_out_t result_s7;
	always_ff @(posedge clk) begin
		result_s7.red_out   <= scl[0][15:8];
		result_s7.green_out <= scl[1][15:8];
		result_s7.blue_out  <= scl[2][15:8];
		result_s7.alpha_out <= alpha_s6;
	end

	assign done = vld[6];
	assign result = result_s7;
endmodule

[design/cmf_checker.sv]
// Port-level checker for the color matrix filter, bound to the top level.
`include "rgba_color_matrix_filter_core_assert.svh"

module cmf_checker import cmf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input pixel_out_t result
);
	logic [2:0] age_q;

	// count edges since reset so the latency check waits for a full pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) age_q <= '0;
		else if (age_q != 3'd7) age_q <= age_q + 3'd1;
	end

	`CMF_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	`CMF_ASSERT_IMPL(a_done_has_pixel, clk, arst_n, done, $past(start && !busy, 7))
	`CMF_ASSERT_IMPL(a_pixel_gives_done, clk, arst_n, age_q == 3'd7 && $past(start && !busy, 7), done)
	`CMF_ASSERT_IMPL(a_premult_bound, clk, arst_n, done, result.red_out <= result.alpha_out && result.green_out <= result.alpha_out && result.blue_out <= result.alpha_out)
endmodule

bind rgba_color_matrix_filter_core cmf_checker u_cmf_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .result(result)
);
